FILE: design/gmc_pkg.sv
// ----------------------------------------------------------------------------
// gmc_pkg
// shared constants, types and register indexes of the graph coloring search
// ----------------------------------------------------------------------------
package gmc_pkg;

    // sizing
    localparam int MAX_NODES  = 16;
    localparam int COLOR_BITS = 4;
    localparam int ROW_SLOTS  = 16;
    localparam int NODE_LIMIT = (MAX_NODES < ROW_SLOTS) ? MAX_NODES : ROW_SLOTS;
    localparam int NODE_BITS  = $clog2(NODE_LIMIT);
    localparam int NUM_COLORS = (1 << COLOR_BITS) - 1;

    // fixed field widths
    localparam int IDX_W    = 4;
    localparam int ROW_W    = 16;
    localparam int COLOR_W  = 4;
    localparam int NCOUNT_W = 5;
    localparam int MAXC_W   = 4;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLORS = 1'b1;
    localparam logic [NCOUNT_W-1:0]  NODE_COUNT_RST = 5'd16;
    localparam logic [MAXC_W-1:0]    MAX_COLORS_RST = 4'd3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EVAL,
        ST_PICK,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_row;
        logic start;
        logic eval;
        logic pick;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic step_ok;
        logic at_last;
        logic at_root;
        logic out_free;
        logic emit_last;
    } dp_stat_t;

endpackage

FILE: design/gmc_ctrl.sv
// ----------------------------------------------------------------------------
// gmc_ctrl
// sequencer for row loading, backtracking steps and result emission
// ----------------------------------------------------------------------------
module gmc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  gmc_pkg::dp_stat_t stat,
    output gmc_pkg::dp_cmd_t  cmd
);

    gmc_pkg::state_t state_reg;
    gmc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gmc_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gmc_pkg::ST_LOAD: begin
                if (s_tvalid && s_tlast) state_next = gmc_pkg::ST_EVAL;
            end
            gmc_pkg::ST_EVAL: begin
                state_next = gmc_pkg::ST_PICK;
            end
            gmc_pkg::ST_PICK: begin
                if ((stat.step_ok && stat.at_last) || (!stat.step_ok && stat.at_root))
                    state_next = gmc_pkg::ST_EMIT;
                else
                    state_next = gmc_pkg::ST_EVAL;
            end
            gmc_pkg::ST_EMIT: begin
                if (stat.out_free && stat.emit_last) state_next = gmc_pkg::ST_LOAD;
            end
            default: state_next = gmc_pkg::ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            gmc_pkg::ST_LOAD: begin
                s_tready     = 1'b1;
                cmd.load_row = s_tvalid;
                cmd.start    = s_tvalid && s_tlast;
            end
            gmc_pkg::ST_EVAL: begin
                cmd.eval = 1'b1;
            end
            gmc_pkg::ST_PICK: begin
                cmd.pick = 1'b1;
            end
            gmc_pkg::ST_EMIT: begin
                cmd.emit = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    // a search step is only ever followed by another step or by emission
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gmc_pkg::ST_PICK |=>
            state_reg == gmc_pkg::ST_EVAL || state_reg == gmc_pkg::ST_EMIT)
        else $error("pick left to an unexpected state");
    // a last row always starts a search
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> state_reg == gmc_pkg::ST_EVAL)
        else $error("search did not start after last row");
    // no emission without a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("emit while output register busy");
`endif

endmodule

FILE: design/gmc_dp.sv
// ----------------------------------------------------------------------------
// gmc_dp
// adjacency store, color store, per-step legal color search, output register
// ----------------------------------------------------------------------------
module gmc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [gmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gmc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [gmc_pkg::S_DATA_W-1:0]        s_tdata,
    input  gmc_pkg::dp_cmd_t                    cmd,
    output gmc_pkg::dp_stat_t                   stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gmc_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int NL = gmc_pkg::NODE_LIMIT;
    localparam int NB = gmc_pkg::NODE_BITS;
    localparam int CB = gmc_pkg::COLOR_BITS;
    localparam int NC = gmc_pkg::NUM_COLORS;

    // configuration
    logic [gmc_pkg::NCOUNT_W-1:0] node_count_reg;
    logic [gmc_pkg::MAXC_W-1:0]   max_colors_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= gmc_pkg::NODE_COUNT_RST;
            max_colors_reg <= gmc_pkg::MAX_COLORS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gmc_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_wdata[gmc_pkg::NCOUNT_W-1:0];
                gmc_pkg::CFG_MAX_COLORS: max_colors_reg <= cfg_wdata[gmc_pkg::MAXC_W-1:0];
                default: node_count_reg <= node_count_reg;
            endcase
        end
    end

    // input fields
    logic [gmc_pkg::IDX_W-1:0] row_index;
    logic [gmc_pkg::ROW_W-1:0] row_bits;
    assign row_index = s_tdata[gmc_pkg::IDX_W-1:0];
    assign row_bits  = s_tdata[gmc_pkg::IDX_W +: gmc_pkg::ROW_W];

    // storage
    logic [NL-1:0] adj_reg    [NL];
    logic [CB-1:0] colors_reg [NL];
    logic [CB-1:0] pmax_reg   [NL];   // largest color among nodes below each node

    logic [NB-1:0] v_reg;
    logic [NB-1:0] n_last_reg;
    logic [CB-1:0] m_reg;
    logic [NC:0]   forbid_reg;
    logic [CB-1:0] cur_reg;
    logic [CB-1:0] lim_reg;
    logic          found_reg;
    logic [NB-1:0] emit_idx_reg;

    // effective node count and color count at search start
    logic [gmc_pkg::NCOUNT_W-1:0] n_eff;
    logic [CB-1:0]                m_eff;
    always_comb begin
        n_eff = node_count_reg;
        if (n_eff == '0) n_eff = gmc_pkg::NCOUNT_W'(1);
        if (n_eff > gmc_pkg::NCOUNT_W'(NL)) n_eff = gmc_pkg::NCOUNT_W'(NL);
        if (32'(max_colors_reg) > NC) m_eff = CB'(NC);
        else m_eff = CB'(max_colors_reg);
    end

    // colors held by neighbors of the current node
    logic [NC:0]   forbid_next;
    logic [NL-1:0] adj_row;
    logic [CB:0]   top_inc;
    logic [CB-1:0] lim_next;
    assign adj_row = adj_reg[v_reg];
    always_comb begin
        forbid_next = '0;
        for (int j = 0; j < NL; j++) begin
            if (adj_row[j]) forbid_next[colors_reg[j]] = 1'b1;
        end
        forbid_next[0] = 1'b0;
        top_inc = {1'b0, pmax_reg[v_reg]} + (CB+1)'(1);
        lim_next = (top_inc < {1'b0, m_reg}) ? top_inc[CB-1:0] : m_reg;
    end

    // smallest legal color above the current one
    logic [NC:0]   cand;
    logic [CB-1:0] pick;
    logic          pick_ok;
    logic [CB-1:0] pmax_up;
    always_comb begin
        cand = '0;
        for (int c = 1; c <= NC; c++) begin
            cand[c] = !forbid_reg[c] && (CB'(c) > cur_reg) && (CB'(c) <= lim_reg);
        end
        pick = '0;
        for (int c = NC; c >= 1; c--) begin
            if (cand[c]) pick = CB'(c);
        end
        pick_ok = |cand;
        pmax_up = (pick > pmax_reg[v_reg]) ? pick : pmax_reg[v_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_row && ({1'b0, row_index} < (gmc_pkg::IDX_W+1)'(NL)))
            adj_reg[row_index[NB-1:0]] <= row_bits[NL-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NL; i++) colors_reg[i] <= '0;
        end else if (cmd.start) begin
            for (int i = 0; i < NL; i++) colors_reg[i] <= '0;
        end else if (cmd.pick) begin
            colors_reg[v_reg] <= pick_ok ? pick : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            pmax_reg[0] <= '0;
        end else if (cmd.pick && pick_ok && (v_reg != NB'(NL-1))) begin
            pmax_reg[v_reg + NB'(1)] <= pmax_up;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg        <= '0;
            emit_idx_reg <= '0;
            found_reg    <= 1'b0;
        end else if (cmd.start) begin
            v_reg        <= '0;
            emit_idx_reg <= '0;
        end else if (cmd.pick) begin
            if (pick_ok) begin
                if (v_reg == n_last_reg) found_reg <= 1'b1;
                else v_reg <= v_reg + NB'(1);
            end else begin
                if (v_reg == '0) found_reg <= 1'b0;
                else v_reg <= v_reg - NB'(1);
            end
        end else if (cmd.emit) begin
            emit_idx_reg <= emit_idx_reg + NB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            n_last_reg <= NB'(n_eff - gmc_pkg::NCOUNT_W'(1));
            m_reg      <= m_eff;
        end
        if (cmd.eval) begin
            forbid_reg <= forbid_next;
            cur_reg    <= colors_reg[v_reg];
            lim_reg    <= lim_next;
        end
    end

    // output register
    logic emit_last;
    logic m_tvalid_reg;
    logic [gmc_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic m_tuser_reg;
    logic m_tlast_reg;
    assign emit_last = !found_reg || (emit_idx_reg == n_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg[gmc_pkg::IDX_W-1:0] <= found_reg ?
                gmc_pkg::IDX_W'(emit_idx_reg) : '0;
            m_tdata_reg[gmc_pkg::IDX_W +: gmc_pkg::COLOR_W] <= found_reg ?
                gmc_pkg::COLOR_W'(colors_reg[emit_idx_reg]) : '0;
            m_tuser_reg <= found_reg;
            m_tlast_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign stat.step_ok   = pick_ok;
    assign stat.at_last   = (v_reg == n_last_reg);
    assign stat.at_root   = (v_reg == '0);
    assign stat.out_free  = !m_tvalid_reg || m_tready;
    assign stat.emit_last = emit_last;

`ifndef SYNTH
    // a successful step leaves a nonzero color on the node it worked on
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pick && pick_ok |=> colors_reg[$past(v_reg)] != '0)
        else $error("colored node left at zero");
    // a failure result carries no color and closes the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[gmc_pkg::IDX_W +: gmc_pkg::COLOR_W] == '0 && m_tlast)
        else $error("malformed failure result");
    // a reported color stays within the color budget of the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[gmc_pkg::IDX_W +: gmc_pkg::COLOR_W] != '0 &&
            m_tdata[gmc_pkg::IDX_W +: gmc_pkg::COLOR_W] <= gmc_pkg::COLOR_W'(m_reg))
        else $error("reported color out of range");
`endif

endmodule

FILE: design/graph_m_coloring_search.sv
// ----------------------------------------------------------------------------
// graph_m_coloring_search
// m-coloring of a small graph by depth-first backtracking
// ----------------------------------------------------------------------------
// Load the adjacency matrix one row per request on the s_ channel, one row per
// cycle while no search or emission is running; the request with s_tlast set
// stores its row and starts the search. The search colors nodes 0..n-1 in
// order, each with the smallest color that no neighbor holds, backing up when
// a node runs out of colors; colors above one plus the largest color used so
// far are skipped. Every search step has an eval state that registers the set
// of colors held by the node's neighbors and a pick state that then picks the
// color and moves forward or back. The number of steps depends on the graph
// (up to exponential in n). A success gives n results (node_index, node_color,
// found=1, tlast on the last node); a failure gives one result with index 0,
// color 0, found 0 and tlast set. Results leave through an output register, so
// the next rows load while the final result still waits. Write node_count
// (index 0, reset 16, 0 counts as 1, saturates at 16) and max_colors (index 1,
// reset 3) only while the block is idle.
// ----------------------------------------------------------------------------
module graph_m_coloring_search (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [gmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gmc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // adjacency rows
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gmc_pkg::S_DATA_W-1:0]       s_tdata,   // row_index[3:0], row_bits[19:4]
    input  logic                               s_tlast,   // last_row
    // coloring results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gmc_pkg::M_DATA_W-1:0]       m_tdata,   // node_index[3:0], node_color[7:4]
    output logic                               m_tuser,   // found
    output logic                               m_tlast    // last
);

    // command and status between sequencer and datapath
    gmc_pkg::dp_cmd_t  cmd;
    gmc_pkg::dp_stat_t stat;

    // sequencer: loading, eval/pick steps of the search, emission
    gmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: adjacency and color stores, legal color picker, output register
    gmc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the graph m-coloring backtracking search
// ----------------------------------------------------------------------------
// Adjacency rows go in on the s_ stream and node colors come back on the m_
// stream. A built-in coloring predictor follows every accepted row and register
// write and queues the colors that each search must report. Every result is
// compared field by field with the oldest queued coloring. A short directed
// table comes first, then random graphs run under several register settings
// and handshake idling profiles.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIMIT       = 1_000_000;  // cycles before the run is abandoned
    localparam int STEP_CAP    = 600;        // longest search a random graph may need
    localparam int DRAIN       = 8;          // settle cycles before writes and at the end
    localparam int PHASE_ITEMS = 16;

    // one reported node color
    typedef struct packed {
        logic [3:0] node;
        logic [3:0] color;
        logic       found;
        logic       tail;
    } coloring_t;

    // directed rows whose outcome is obvious carry it here
    typedef enum logic [1:0] {
        TYPED_NONE,
        TYPED_FAIL,
        TYPED_ALL_ONE
    } typed_t;

    typedef enum logic {
        DIR_ROW,
        DIR_CFG
    } dir_kind_t;

    typedef struct packed {
        dir_kind_t   kind;
        logic [4:0]  a;         // row index, or node_count
        logic [15:0] b;         // row bits, or max_colors
        logic        last_row;
        typed_t      typed;
    } dir_step_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [gmc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gmc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [gmc_pkg::S_DATA_W-1:0]   s_tdata   = '0;   // row_index[3:0], row_bits[19:4]
    logic                           s_tlast   = 1'b0; // last_row
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [gmc_pkg::M_DATA_W-1:0]   m_tdata;          // node_index[3:0], node_color[7:4]
    logic                           m_tuser;          // found
    logic                           m_tlast;          // last

    // handshake idling, percent of cycles
    int          idle_pct  = 0;
    int          stall_pct = 0;
    typed_t      typed_check = TYPED_NONE;
    coloring_t   expected_colors[$];
    int          errors     = 0;
    int          sent_items = 0;
    int unsigned cycles     = 0;

    // predictor copy of the block, advanced on accepted requests and writes
    logic [255:0] adj_rows     = '0;
    logic [4:0]   node_count_q = gmc_pkg::NODE_COUNT_RST;
    logic [3:0]   max_colors_q = gmc_pkg::MAX_COLORS_RST;

    // stimulus-side view, one request ahead of the predictor
    logic [255:0] plan_rows    = '0;
    logic [15:0]  plan_written = '0;
    logic [4:0]   plan_nc      = gmc_pkg::NODE_COUNT_RST;
    logic [3:0]   plan_mc      = gmc_pkg::MAX_COLORS_RST;

    graph_m_coloring_search uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // node count as the search sees it: zero counts as one, saturates at the limit
    function automatic int eff_nodes(input logic [4:0] nc);
        if (nc == 0)
            return 1;
        if (nc > gmc_pkg::NODE_LIMIT)
            return gmc_pkg::NODE_LIMIT;
        return int'(nc);
    endfunction

    function automatic int eff_colors(input logic [3:0] mc);
        return (mc > gmc_pkg::NUM_COLORS) ? gmc_pkg::NUM_COLORS : int'(mc);
    endfunction

    // depth-first coloring with the symmetry cut; returns the number of
    // search steps taken, giving up once cap is reached
    function automatic int color_search(input logic [255:0] adj, input int n, input int m,
                                        input int cap, output logic [63:0] colors,
                                        output logic found);
        int   v;
        int   top;
        int   lim;
        int   c;
        int   steps;
        logic ok;
        logic busy;
        colors = '0;
        found  = 1'b0;
        busy   = 1'b1;
        v      = 0;
        steps  = 0;
        while (busy) begin
            if (v >= n) begin
                found = 1'b1;
                busy  = 1'b0;
            end else if (steps >= cap) begin
                busy = 1'b0;
            end else begin
                steps++;
                // colors above one plus the highest used so far are relabelings
                top = 0;
                for (int k = 0; k < v; k++)
                    if (int'(colors[k*4 +: 4]) > top)
                        top = int'(colors[k*4 +: 4]);
                lim = (top + 1 < m) ? top + 1 : m;
                c   = int'(colors[v*4 +: 4]) + 1;
                ok  = 1'b0;
                while (!ok && c <= lim) begin
                    ok = 1'b1;
                    // only this node's own row counts, bits at or above n ignored
                    for (int j = 0; j < n; j++)
                        if (adj[v*16 + j] && int'(colors[j*4 +: 4]) == c)
                            ok = 1'b0;
                    if (!ok)
                        c++;
                end
                if (ok) begin
                    colors[v*4 +: 4] = 4'(c);
                    v++;
                end else begin
                    colors[v*4 +: 4] = 4'd0;
                    if (v == 0)
                        busy = 1'b0;
                    else
                        v--;
                end
            end
        end
        return steps;
    endfunction

    function automatic dir_step_t step_entry(input dir_kind_t kind, input int a, input int b,
                                             input logic last_row, input typed_t typed);
        dir_step_t st;
        st.kind     = kind;
        st.a        = 5'(a);
        st.b        = 16'(b);
        st.last_row = last_row;
        st.typed    = typed;
        return st;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        errors++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endtask

    // ------------------------------------------------------------------------
    // monitor: predicts on every accepted row, checks every accepted result
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        coloring_t   got;
        coloring_t   want;
        logic [63:0] cols;
        logic        found;
        int          n;
        if (aresetn) begin
            if (cfg_wr_en) begin
                if (cfg_index == gmc_pkg::CFG_NODE_COUNT)
                    node_count_q = cfg_wdata;
                else
                    max_colors_q = cfg_wdata[3:0];
            end
            if (s_tvalid && s_tready) begin
                adj_rows[s_tdata[3:0]*16 +: 16] = s_tdata[19:4];
                if (s_tlast) begin
                    n = eff_nodes(node_count_q);
                    if (typed_check == TYPED_FAIL) begin
                        found = 1'b0;
                    end else if (typed_check == TYPED_ALL_ONE) begin
                        found = 1'b1;
                        cols  = {16{4'd1}};
                    end else begin
                        void'(color_search(adj_rows, n, eff_colors(max_colors_q),
                                           32'h7fff_ffff, cols, found));
                    end
                    if (found) begin
                        for (int i = 0; i < n; i++) begin
                            want.node  = 4'(i);
                            want.color = cols[i*4 +: 4];
                            want.found = 1'b1;
                            want.tail  = (i == n - 1);
                            expected_colors = {expected_colors, want};
                        end
                    end else begin
                        // failure is one result: index 0, color 0, found 0, last
                        want = '0;
                        want.tail = 1'b1;
                        expected_colors = {expected_colors, want};
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                got.node  = m_tdata[3:0];
                got.color = m_tdata[7:4];
                got.found = m_tuser;
                got.tail  = m_tlast;
                if (expected_colors.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none, actual node %0d color %0d",
                             $time, got.node, got.color);
                end else begin
                    want = expected_colors.pop_front();
                    if (got.node != want.node)
                        flag_mismatch("node_index", int'(want.node), int'(got.node));
                    if (got.color != want.color)
                        flag_mismatch("node_color", int'(want.color), int'(got.color));
                    if (got.found != want.found)
                        flag_mismatch("found", int'(want.found), int'(got.found));
                    if (got.tail != want.tail)
                        flag_mismatch("last", int'(want.tail), int'(got.tail));
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------------

    // one row request; returns at the falling edge after it was taken
    task automatic send_row(input logic [3:0] idx, input logic [15:0] bits,
                            input logic last_row, input typed_t typed);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        typed_check = typed;
        s_tvalid   <= 1'b1;
        s_tdata    <= {4'b0, bits, idx};
        s_tlast    <= last_row;
        plan_rows[idx*16 +: 16] = bits;
        plan_written[idx]       = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_items++;
        @(negedge aclk);
        typed_check = TYPED_NONE;
    endtask

    // sender holds off until every queued coloring is back, then settles
    task automatic wait_idle(input int drain);
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (expected_colors.size() != 0);
        repeat (drain)
            @(negedge aclk);
    endtask

    // both registers, back to back; only called while the block is idle
    task automatic set_config(input logic [4:0] nc, input logic [4:0] mc);
        cfg_wr_en <= 1'b1;
        cfg_index <= gmc_pkg::CFG_NODE_COUNT;
        cfg_wdata <= nc;
        @(negedge aclk);
        cfg_index <= gmc_pkg::CFG_MAX_COLORS;
        cfg_wdata <= mc;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        plan_nc = nc;
        plan_mc = mc[3:0];
    endtask

    // a fresh random graph over every node in use, rows in shuffled order,
    // last_row on the final one; graphs needing a long search are redrawn
    task automatic send_graph();
        int           ne;
        int           nm;
        int           pct;
        int           t;
        int           k;
        logic         sym;
        logic         fits;
        logic         found;
        logic [15:0]  row;
        logic [63:0]  cols;
        logic [255:0] trial;
        logic [3:0]   order [16];
        ne = eff_nodes(plan_nc);
        nm = eff_colors(plan_mc);
        // a little noise ahead of the graph
        repeat ($urandom_range(2))
            send_row(4'($urandom_range(15)), 16'($urandom), 1'b0, TYPED_NONE);
        fits = 1'b0;
        for (int tries = 0; tries < 20 && !fits; tries++) begin
            trial = plan_rows;
            pct   = 10 + 15 * $urandom_range(3);
            sym   = ($urandom_range(4) != 0);
            // junk above the node count must be ignored
            for (int i = 0; i < ne; i++) begin
                row = $urandom_range(1) ? 16'($urandom) : 16'h0;
                for (int j = 0; j < ne; j++)
                    row[j] = 1'b0;
                trial[i*16 +: 16] = row;
            end
            for (int i = 0; i < ne; i++)
                for (int j = 0; j < ne; j++)
                    if (i != j && $urandom_range(99) < pct) begin
                        if (!sym) begin
                            trial[i*16 + j] = 1'b1;
                        end else if (j < i) begin
                            trial[i*16 + j] = 1'b1;
                            trial[j*16 + i] = 1'b1;
                        end
                    end
            fits = (color_search(trial, ne, nm, STEP_CAP + 1, cols, found) <= STEP_CAP);
        end
        if (!fits)
            for (int i = 0; i < ne; i++)
                trial[i*16 +: 16] = 16'h0;
        for (int i = 0; i < ne; i++)
            order[i] = 4'(i);
        for (int i = ne - 1; i > 0; i--) begin
            t        = $urandom_range(i);
            k        = int'(order[i]);
            order[i] = order[t];
            order[t] = 4'(k);
        end
        for (int i = 0; i < ne; i++)
            send_row(order[i], trial[order[i]*16 +: 16], i == ne - 1, TYPED_NONE);
    endtask

    // a few stray rows, then a closing row that starts a search over whatever the
    // matrix holds, if every row in use was written and that search stays short
    task automatic send_broken();
        int           ne;
        logic [3:0]   idx;
        logic [15:0]  bits;
        logic [31:0]  need;
        logic         found;
        logic         go;
        logic [63:0]  cols;
        logic [255:0] trial;
        ne = eff_nodes(plan_nc);
        repeat ($urandom_range(1, 4))
            send_row(4'($urandom_range(15)), 16'($urandom), 1'b0, TYPED_NONE);
        idx   = 4'($urandom_range(15));
        bits  = 16'($urandom);
        trial = plan_rows;
        trial[idx*16 +: 16] = bits;
        need  = (32'd1 << ne) - 1;
        // never start a search over a row that was never written
        go = (((plan_written | (16'd1 << idx)) & need[15:0]) == need[15:0]) &&
             (color_search(trial, ne, eff_colors(plan_mc), STEP_CAP + 1, cols, found)
              <= STEP_CAP);
        send_row(idx, bits, go, TYPED_NONE);
    endtask

    initial begin : stimulus
        dir_step_t directed[$];
        dir_step_t st;
        int        phase_end;

        // directed table
        // reset settings (16 nodes, 3 colors): one-sided edges out of node 0 only,
        // so every node takes color 1
        directed = {directed, step_entry(DIR_ROW, 0, 16'hFFFF, 1'b0, TYPED_NONE)};
        for (int i = 1; i < 15; i++)
            directed = {directed, step_entry(DIR_ROW, i, 16'h0000, 1'b0, TYPED_NONE)};
        directed = {directed, step_entry(DIR_ROW, 15, 16'h0000, 1'b1, TYPED_ALL_ONE)};
        // node count zero acts as one; zero colors always fail
        directed = {directed, step_entry(DIR_CFG, 0, 0, 1'b0, TYPED_NONE)};
        directed = {directed, step_entry(DIR_ROW, 0, 16'h0000, 1'b1, TYPED_FAIL)};
        // node count saturates, all fifteen colors
        directed = {directed, step_entry(DIR_CFG, 31, 15, 1'b0, TYPED_NONE)};
        directed = {directed, step_entry(DIR_ROW, 15, 16'hFFFF, 1'b1, TYPED_NONE)};
        // four-clique with three colors, stray bits above the node count
        directed = {directed, step_entry(DIR_CFG, 4, 3, 1'b0, TYPED_NONE)};
        directed = {directed, step_entry(DIR_ROW, 0, 16'h000E, 1'b0, TYPED_NONE)};
        directed = {directed, step_entry(DIR_ROW, 1, 16'h000D, 1'b0, TYPED_NONE)};
        directed = {directed, step_entry(DIR_ROW, 2, 16'h000B, 1'b0, TYPED_NONE)};
        directed = {directed, step_entry(DIR_ROW, 3, 16'hFFF7, 1'b1, TYPED_FAIL)};
        // same clique colors fine with four
        directed = {directed, step_entry(DIR_CFG, 4, 4, 1'b0, TYPED_NONE)};
        directed = {directed, step_entry(DIR_ROW, 2, 16'h000B, 1'b1, TYPED_NONE)};
        // single node with a self edge
        directed = {directed, step_entry(DIR_CFG, 1, 1, 1'b0, TYPED_NONE)};
        directed = {directed, step_entry(DIR_ROW, 0, 16'hFFFF, 1'b1, TYPED_ALL_ONE)};
        // one-sided edge back to node 0 with one color
        directed = {directed, step_entry(DIR_CFG, 2, 1, 1'b0, TYPED_NONE)};
        directed = {directed, step_entry(DIR_ROW, 1, 16'h0001, 1'b1, TYPED_FAIL)};

        repeat (6)
            @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            st = directed[i];
            if (st.kind == DIR_CFG) begin
                wait_idle(DRAIN);
                set_config(st.a, st.b[4:0]);
            end else begin
                send_row(st.a[3:0], st.b, st.last_row, st.typed);
            end
        end
        wait_idle(DRAIN);

        // random phases, each with its own settings and idling profile
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            case (ph)
                0: set_config(5'd5, 5'd3);
                1: set_config(5'd16, 5'd4);
                2: set_config(5'd8, 5'd2);
                3: set_config(5'd31, 5'd15);
                4: set_config(5'd3, 5'd0);
                default: set_config(5'd12, 5'h13);  // upper data bit is dropped
            endcase
            phase_end = sent_items + PHASE_ITEMS;
            while (sent_items < phase_end) begin
                if ($urandom_range(4) != 0)
                    send_graph();
                else
                    send_broken();
                // sender waits out the whole coloring now and then, and always in phase 2
                if (ph == 2 || $urandom_range(5) == 0)
                    wait_idle(0);
            end
            wait_idle(DRAIN);
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
